// ----- rtl/usbasc_pkg.sv -----
`timescale 1ns / 1ps

package usbasc_pkg;

    // accessory classes
    localparam logic [2:0] CLS_NONE = 3'd0;
    localparam logic [2:0] CLS_USB  = 3'd1;
    localparam logic [2:0] CLS_UART = 3'd2;
    localparam logic [2:0] CLS_AV   = 3'd3;
    localparam logic [2:0] CLS_ETC  = 3'd4;

    // event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_ATTACH  = 2'd1;
    localparam logic [1:0] EV_DETACH  = 2'd2;
    localparam logic [1:0] EV_ILLEGAL = 2'd3;

    // interrupt flag bits
    localparam logic [15:0] INT_ATTACH     = 16'h0001;
    localparam logic [15:0] INT_DETACH     = 16'h0002;
    localparam logic [15:0] INT_RES_ATTACH = 16'h0200;

    // device type masks
    localparam logic [15:0] DT_AUDIO        = 16'h8003;
    localparam logic [15:0] DT_MIC          = 16'h0001;
    localparam logic [15:0] DT_USB          = 16'h03A4;
    localparam logic [15:0] DT_UART         = 16'h0C08;
    localparam logic [15:0] DT_AV           = 16'h4000;
    localparam logic [15:0] DT_CHARGER      = 16'h0060;
    localparam logic [15:0] DT_JIG_USB_ON   = 16'h0100;
    localparam logic [15:0] DT_JIG_USB_OFF  = 16'h0200;
    localparam logic [15:0] DT_JIG_UART_ON  = 16'h0400;
    localparam logic [15:0] DT_JIG_UART_OFF = 16'h0800;

    // adc codes
    localparam logic [7:0] ADC_CHG_A = 8'h17;
    localparam logic [7:0] ADC_CHG_B = 8'h1B;
    localparam logic [7:0] ADC_RES_USB = 8'h0F;
    localparam logic [7:0] ADC_RES4  = 8'h11;
    localparam logic [7:0] ADC_RES5  = 8'h12;

    // switch words
    localparam logic [12:0] SW_USB_BASE  = 13'h0225;
    localparam logic [12:0] SW_UART_BASE = 13'h006C;
    localparam logic [12:0] SW_AV        = 13'h0190;
    localparam logic [12:0] SW_CHARGER   = 13'h0001;
    localparam logic [12:0] SW_RES4      = 13'h0088;
    localparam logic [12:0] SW_RES5      = 13'h024A;
    localparam logic [12:0] SW_ID2IDBP   = 13'h0200;
    localparam logic [12:0] SW_JIG_HIGH  = 13'h0400;
    localparam logic [12:0] SW_BOOT_HIGH = 13'h0800;
    localparam logic [12:0] SW_VBUS2OUT  = 13'h0001;

    function automatic logic [12:0] usb_word(input logic boot_on, input logic boot_off);
        logic [12:0] w;
        w = SW_USB_BASE;
        if (boot_on)
        begin
            w = SW_USB_BASE | SW_JIG_HIGH | SW_BOOT_HIGH;
        end
        else if (boot_off)
        begin
            w = SW_USB_BASE | SW_JIG_HIGH;
        end
        return w;
    endfunction

    function automatic logic [12:0] uart_word(input logic boot_on, input logic boot_off);
        logic [12:0] w;
        w = SW_UART_BASE;
        if (boot_on)
        begin
            w = SW_UART_BASE | SW_JIG_HIGH | SW_BOOT_HIGH | SW_VBUS2OUT;
        end
        else if (boot_off)
        begin
            w = SW_UART_BASE | SW_JIG_HIGH | SW_VBUS2OUT;
        end
        return w;
    endfunction

endpackage

// ----- rtl/usb_accessory_switch_classifier.sv -----
`timescale 1ns / 1ps

// micro-usb accessory switch classifier
//
// input channel (in_valid / in_stall): one interrupt event word per handshake,
//   carrying interrupt_flags, dev_type and adc_value
// output channel (out_valid / out_stall): one result word per event, carrying
//   event_code, accessory_class, switch_word, switch_written, automatic_switching
// config: cfg_write with cfg_data writes manual_sw; the user must write only
//   while no event is in flight, which the block does not enforce
// flow: an accepted event lands in the input register, is classified against
//   the kept state and moves into the result register as soon as that register
//   is free to take it
// throughput: one event per cycle while the receiver does not stall, set by the
//   state update that sits between the input register and the result register
// stall: when the receiver stalls with a result pending, the input register
//   holds its event and in_stall rises in the same cycle; nothing is dropped
// reset (rst_n low, async): both registers empty, no accessory, jig flags
//   clear, switch word all open, automatic switching on, manual_sw off
module usb_accessory_switch_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] interrupt_flags,
    input  logic [15:0] dev_type,
    input  logic [7:0]  adc_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_code,
    output logic [2:0]  accessory_class,
    output logic [12:0] switch_word,
    output logic        switch_written,
    output logic        automatic_switching
);
    import usbasc_pkg::*;

    // config
    logic manual_sw_reg;

    // input register
    logic        in_valid_reg;
    logic [15:0] flags_reg;
    logic [15:0] dt_reg;
    logic [7:0]  adc_reg;

    // kept state
    logic [2:0]  class_reg,    class_next;
    logic        boot_on_reg,  boot_on_next;
    logic        boot_off_reg, boot_off_next;
    logic        temp_man_reg, temp_man_next;
    logic [12:0] sw_reg,       sw_next;
    logic        auto_reg,     auto_next;

    // result register
    logic        out_valid_reg;
    logic [1:0]  code_reg,     code_next;
    logic        written_reg,  written_next;

    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // classification of the event held in the input register
    always_comb
    begin
        logic charger_adc;
        logic [2:0] cls;
        charger_adc   = (adc_reg == ADC_CHG_A) || (adc_reg == ADC_CHG_B);
        cls           = class_reg;
        class_next    = class_reg;
        boot_on_next  = boot_on_reg;
        boot_off_next = boot_off_reg;
        temp_man_next = temp_man_reg;
        sw_next       = sw_reg;
        auto_next     = auto_reg;
        code_next     = EV_NONE;
        written_next  = 1'b0;

        priority if ((flags_reg & INT_ATTACH) != '0)
        begin
            if ((flags_reg & INT_DETACH) != '0)
            begin
                // both flags: reinit, word back to open
                code_next = EV_ILLEGAL;
                sw_next   = '0;
                auto_next = !manual_sw_reg;
            end
            else
            begin
                code_next     = EV_ATTACH;
                temp_man_next = 1'b0;
                if ((dt_reg & DT_AUDIO) != '0)
                begin
                    cls = CLS_ETC;
                end
                if ((dt_reg & DT_USB) != '0)
                begin
                    cls           = CLS_USB;
                    boot_on_next  = (dt_reg & DT_JIG_USB_ON) != '0;
                    boot_off_next = (dt_reg & DT_JIG_USB_OFF) != '0;
                end
                if ((dt_reg & DT_UART) != '0)
                begin
                    cls           = CLS_UART;
                    boot_on_next  = (dt_reg & DT_JIG_UART_ON) != '0;
                    boot_off_next = (dt_reg & DT_JIG_UART_OFF) != '0;
                end
                if ((dt_reg & DT_AV) != '0)
                begin
                    cls = CLS_AV;
                end
                // charger only claims an otherwise empty class
                if (((dt_reg & DT_CHARGER) != '0) && (cls == CLS_NONE))
                begin
                    cls = CLS_ETC;
                end
                if (charger_adc)
                begin
                    cls = CLS_ETC;
                end
                class_next = cls;

                if (manual_sw_reg)
                begin
                    if ((dt_reg & DT_USB) != '0)
                    begin
                        sw_next      = usb_word(boot_on_next, boot_off_next);
                        written_next = 1'b1;
                    end
                    if ((dt_reg & DT_UART) != '0)
                    begin
                        sw_next      = uart_word(boot_on_next, boot_off_next);
                        written_next = 1'b1;
                    end
                    if ((dt_reg & DT_AV) != '0)
                    begin
                        sw_next      = SW_AV;
                        written_next = 1'b1;
                    end
                    // mic adds the id path to the word built so far
                    if ((dt_reg & DT_MIC) != '0)
                    begin
                        sw_next      = sw_next | SW_ID2IDBP;
                        written_next = 1'b1;
                    end
                    if (((dt_reg & DT_CHARGER) != '0) || charger_adc)
                    begin
                        sw_next      = SW_CHARGER;
                        written_next = 1'b1;
                    end
                end
            end
        end
        else if ((flags_reg & INT_RES_ATTACH) != '0)
        begin
            // reserved attach: software takes the switch over
            code_next     = EV_ATTACH;
            temp_man_next = 1'b1;
            class_next    = CLS_ETC;
            auto_next     = 1'b0;
            priority if (adc_reg == ADC_RES_USB)
            begin
                boot_on_next  = (dt_reg & DT_JIG_USB_ON) != '0;
                boot_off_next = (dt_reg & DT_JIG_USB_OFF) != '0;
                sw_next       = usb_word(boot_on_next, boot_off_next);
                written_next  = 1'b1;
            end
            else if (adc_reg == ADC_RES4)
            begin
                sw_next      = SW_RES4;
                written_next = 1'b1;
            end
            else if (adc_reg == ADC_RES5)
            begin
                sw_next      = SW_RES5;
                written_next = 1'b1;
            end
            else
            begin
                // unknown reserved code writes no word
                sw_next = sw_reg;
            end
        end
        else if ((flags_reg & INT_DETACH) != '0)
        begin
            code_next = EV_DETACH;
            priority if (manual_sw_reg)
            begin
                sw_next      = '0;
                written_next = 1'b1;
            end
            else if (temp_man_reg)
            begin
                // leave temporary manual, hand back to automatic
                temp_man_next = 1'b0;
                sw_next       = '0;
                written_next  = 1'b1;
                auto_next     = 1'b1;
            end
            else
            begin
                sw_next = sw_reg;
            end
        end
        else
        begin
            code_next = EV_NONE;
        end
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_sw_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            manual_sw_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            flags_reg <= interrupt_flags;
            dt_reg    <= dev_type;
            adc_reg   <= adc_value;
        end
    end

    // kept state, updated as each event moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg    <= CLS_NONE;
            boot_on_reg  <= 1'b0;
            boot_off_reg <= 1'b0;
            temp_man_reg <= 1'b0;
            sw_reg       <= '0;
            auto_reg     <= 1'b1;
        end
        else if (advance)
        begin
            class_reg    <= class_next;
            boot_on_reg  <= boot_on_next;
            boot_off_reg <= boot_off_next;
            temp_man_reg <= temp_man_next;
            sw_reg       <= sw_next;
            auto_reg     <= auto_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            code_reg    <= code_next;
            written_reg <= written_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign event_code          = code_reg;
    assign accessory_class     = class_reg;
    assign switch_word         = sw_reg;
    assign switch_written      = written_reg;
    assign automatic_switching = auto_reg;

    // a word rewrite only comes from an attach or a detach
    a_written_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && switch_written) |-> (event_code == EV_ATTACH || event_code == EV_DETACH))
        else $error("switch word rewrite on an event that cannot write it");

    // reinit always leaves the switch open
    a_illegal_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_code == EV_ILLEGAL) |-> (switch_word == '0 && !switch_written))
        else $error("illegal event left the switch word set");

    // kept state only moves when an event is retired
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> ($stable(sw_reg) && $stable(class_reg) && $stable(auto_reg)))
        else $error("kept state changed without an event");

    // an input stall means a held event waits on a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid && out_stall))
        else $error("input stalled without a pending result");

endmodule
